FILE: sv/sitoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg: shared types and constants for the decimal text converter
// Widths, ASCII codes, the per-number text buffer type and the reciprocal
// constants used to divide the magnitude by powers of ten.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // Field widths
    localparam int VALUE_W = 16;
    localparam int CHAR_W  = 8;

    // Positions printed after the optional sign (range 5 to 10)
    localparam int DIGIT_COUNT = 5;
    // A 16-bit magnitude (at most 32768) never has more than five digits
    localparam int MAG_DIGITS  = 5;
    // Buffer: sign slot followed by DIGIT_COUNT positions
    localparam int TEXT_LEN    = DIGIT_COUNT + 1;
    localparam int IDX_W       = $clog2(TEXT_LEN);
    localparam int PROD_W      = 2 * VALUE_W;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Index of the sign slot, of the first position and of the final byte in the text buffer
    localparam logic [IDX_W-1:0] IDX_SIGN  = '0;
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DIGIT_COUNT);

    // floor(mag / 10^k) = (mag * ceil(2^s / 10^k)) >> s, exact for mag <= 2^15
    localparam int QUOT_SHIFT [1:MAG_DIGITS-1] = '{19, 22, 25, 29};
    localparam logic [VALUE_W-1:0] QUOT_RECIP [1:MAG_DIGITS-1] = '{
        VALUE_W'(((2 ** 19) + 9) / 10),
        VALUE_W'(((2 ** 22) + 99) / 100),
        VALUE_W'(((2 ** 25) + 999) / 1000),
        VALUE_W'(((2 ** 29) + 9999) / 10000)
    };

    // Sample taken from the input register into the converter
    typedef struct packed {
        logic                      neg;
        logic [VALUE_W-1:0]        raw;
    } t_conv_in;

    // Byte 0 is the sign slot, bytes 1..DIGIT_COUNT are the positions,
    // most significant first
    typedef logic [TEXT_LEN-1:0][CHAR_W-1:0] t_text;

endpackage

FILE: sv/sitoa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_in_if: input channel of the decimal text converter
// Valid/ready handshake carrying one signed 16-bit value per beat.
// ----------------------------------------------------------------------------
interface sitoa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sitoa_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: sv/sitoa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_out_if: output channel of the decimal text converter
// Valid/ready handshake carrying one ASCII byte and an end-of-number flag.
// ----------------------------------------------------------------------------
interface sitoa_out_if;
    logic                           valid;
    logic                           ready;
    logic [sitoa_pkg::CHAR_W-1:0]   char_code;
    logic                           is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

FILE: sv/sitoa_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_conv: binary to right-aligned decimal text
// Forms the magnitude, divides it by each power of ten in parallel with
// reciprocal multiplies, and builds the sign slot plus the padded positions.
// ----------------------------------------------------------------------------
module sitoa_conv (
    input  sitoa_pkg::t_conv_in i_conv,
    output sitoa_pkg::t_text    o_text
);

    logic [sitoa_pkg::VALUE_W-1:0] mag;
    logic [sitoa_pkg::VALUE_W-1:0] quot [0:sitoa_pkg::MAG_DIGITS];
    logic [sitoa_pkg::CHAR_W-1:0]  pos  [0:sitoa_pkg::DIGIT_COUNT-1];

    // Negate without overflow: 0x8000 stays 0x8000, i.e. 32768
    assign mag = i_conv.neg ? sitoa_pkg::VALUE_W'(-i_conv.raw) : i_conv.raw;

    // quot[k] = floor(mag / 10^k); the quotients are independent of each other
    always_comb begin
        logic [sitoa_pkg::PROD_W-1:0] prod;
        quot[0] = mag;
        quot[sitoa_pkg::MAG_DIGITS] = '0;
        for (int k = 1; k < sitoa_pkg::MAG_DIGITS; k++) begin
            prod    = sitoa_pkg::PROD_W'(mag) * sitoa_pkg::PROD_W'(sitoa_pkg::QUOT_RECIP[k]);
            quot[k] = sitoa_pkg::VALUE_W'(prod >> sitoa_pkg::QUOT_SHIFT[k]);
        end
    end

    // Digit k is quot[k] - 10*quot[k+1]; blank the position once the
    // quotient runs out, but always show the units digit
    always_comb begin
        logic [sitoa_pkg::VALUE_W-1:0] rem;
        for (int k = 0; k < sitoa_pkg::DIGIT_COUNT; k++) begin
            if (k < sitoa_pkg::MAG_DIGITS) begin
                rem = quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1));
                if ((quot[k] != '0) || (k == 0)) begin
                    pos[k] = sitoa_pkg::CH_ZERO + sitoa_pkg::CHAR_W'(rem[3:0]);
                end else begin
                    pos[k] = sitoa_pkg::CH_SPACE;
                end
            end else begin
                rem    = '0;
                pos[k] = sitoa_pkg::CH_SPACE;
            end
        end
    end

    // Sign slot first, then positions from most significant down
    always_comb begin
        o_text[0] = sitoa_pkg::CH_MINUS;
        for (int j = 1; j < sitoa_pkg::TEXT_LEN; j++) begin
            o_text[j] = pos[sitoa_pkg::DIGIT_COUNT - j];
        end
    end

endmodule

FILE: sv/signed_int_to_padded_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_ascii_top: signed 16-bit to decimal ASCII
// Converts each signed value into right-aligned decimal text, one byte per
// output beat.
// ----------------------------------------------------------------------------
// Each accepted value produces its decimal text on the output channel, one
// ASCII byte per beat, most significant position first: a '-' for a negative
// value, then five positions right-aligned with leading spaces (zero prints
// as four spaces and '0'; -32768 prints in full). is_last marks the final
// byte. A number takes 5 output bytes when non-negative and 6 when negative.
// After a value is accepted it waits in the input register, then passes
// through the converter into the text buffer, from which its bytes are sent.
// The input register takes the next value while the current text is still
// draining, and the text buffer reloads in the same cycle that its last byte
// is taken, so back-to-back numbers leave no gap on the output.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_ascii_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sitoa_in_if.sink      i_in_ch,
    sitoa_out_if.source   o_out_ch
);

    // Input register
    logic                        r_in_vld;
    logic                        n_in_vld;
    sitoa_pkg::t_conv_in         r_in;
    sitoa_pkg::t_conv_in         n_in;

    // Text buffer and read pointer
    logic                        r_txt_vld;
    logic                        n_txt_vld;
    sitoa_pkg::t_text            r_text;
    sitoa_pkg::t_text            n_text;
    logic [sitoa_pkg::IDX_W-1:0] r_idx;
    logic [sitoa_pkg::IDX_W-1:0] n_idx;

    sitoa_pkg::t_text            conv_text;
    logic                        in_fire;
    logic                        out_fire;
    logic                        at_last;
    logic                        txt_free;
    logic                        advance;

    sitoa_conv u_conv (
        .i_conv (r_in),
        .o_text (conv_text)
    );

    // Handshake terms
    assign at_last  = (r_idx == sitoa_pkg::IDX_LAST);
    assign out_fire = o_out_ch.valid && o_out_ch.ready;
    // The buffer is free when empty or when its last byte leaves this cycle
    assign txt_free = !r_txt_vld || (out_fire && at_last);
    assign advance  = r_in_vld && txt_free;
    assign i_in_ch.ready = !r_in_vld || txt_free;
    assign in_fire  = i_in_ch.valid && i_in_ch.ready;

    // Output beat straight from the buffer slot under the pointer
    assign o_out_ch.valid     = r_txt_vld;
    assign o_out_ch.char_code = r_text[r_idx];
    assign o_out_ch.is_last   = at_last;

    // Input register: load on a new beat, drop when moved into the buffer
    always_comb begin
        n_in_vld = r_in_vld;
        n_in     = r_in;
        if (in_fire) begin
            n_in_vld = 1'b1;
            n_in.raw = i_in_ch.value;
            n_in.neg = i_in_ch.value[sitoa_pkg::VALUE_W-1];
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
    end

    // Text buffer: load converted text, skip the sign slot for a
    // non-negative value, advance one byte per output beat
    always_comb begin
        n_txt_vld = r_txt_vld;
        n_text    = r_text;
        n_idx     = r_idx;
        if (advance) begin
            n_txt_vld = 1'b1;
            n_text    = conv_text;
            n_idx     = r_in.neg ? sitoa_pkg::IDX_SIGN : sitoa_pkg::IDX_FIRST;
        end else if (out_fire) begin
            if (at_last) begin
                n_txt_vld = 1'b0;
            end else begin
                n_idx = r_idx + sitoa_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_txt_vld <= 1'b0;
            r_idx     <= sitoa_pkg::IDX_SIGN;
        end else begin
            r_in_vld  <= n_in_vld;
            r_txt_vld <= n_txt_vld;
            r_idx     <= n_idx;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_text <= n_text;
    end

    // The final byte of a number is always a digit
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.is_last) |->
        ((o_out_ch.char_code >= sitoa_pkg::CH_ZERO) &&
         (o_out_ch.char_code <= sitoa_pkg::CH_NINE)))
        else $error("final byte of a number is not a decimal digit");

    // A sign byte only ever comes from the sign slot, never last
    a_sign_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && (r_idx == sitoa_pkg::IDX_SIGN)) |->
        ((o_out_ch.char_code == sitoa_pkg::CH_MINUS) && !o_out_ch.is_last))
        else $error("sign slot emitted something other than a leading minus");

    // A number's text does not break up once started
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_out_ch.is_last) |=> o_out_ch.valid)
        else $error("output text interrupted before its last byte");

    // An accepted value is held until it moves into the text buffer
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !txt_free) |=> (r_in_vld && $stable(r_in)))
        else $error("input register lost a value before conversion");

endmodule
